// File: hw/rtl/jmsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsp_pkg
// Shared types, marker codes and the marker classifier of the JPEG marker
// segment parser.
// ----------------------------------------------------------------------------
package jmsp_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX   = 3'd0,
    PH_CODE     = 3'd1,
    PH_LEN_HI   = 3'd2,
    PH_LEN_LO   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_SCAN     = 3'd5,
    PH_STOPPED  = 3'd6,
    PH_FINISHED = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_MARKER     = 3'd1,
    EV_PAYLOAD    = 3'd2,
    EV_SOS_DONE   = 3'd3,
    EV_EOI        = 3'd4,
    EV_BAD_MARKER = 3'd5,
    EV_BAD_LENGTH = 3'd6,
    EV_TRUNCATED  = 3'd7
  } event_t;

  typedef enum logic [3:0] {
    CL_SOI   = 4'd0,
    CL_SOF0  = 4'd1,
    CL_SOF2  = 4'd2,
    CL_DHT   = 4'd3,
    CL_APP0  = 4'd4,
    CL_APPN  = 4'd5,
    CL_RST   = 4'd6,
    CL_SOS   = 4'd7,
    CL_DQT   = 4'd8,
    CL_DRI   = 4'd9,
    CL_OTHER = 4'd10
  } class_t;

  localparam logic [7:0] BYTE_PREFIX = 8'hFF;
  localparam logic [7:0] CODE_SOF0   = 8'hC0;
  localparam logic [7:0] CODE_SOF2   = 8'hC2;
  localparam logic [7:0] CODE_DHT    = 8'hC4;
  localparam logic [7:0] CODE_RST0   = 8'hD0;
  localparam logic [7:0] CODE_RST7   = 8'hD7;
  localparam logic [7:0] CODE_SOI    = 8'hD8;
  localparam logic [7:0] CODE_EOI    = 8'hD9;
  localparam logic [7:0] CODE_SOS    = 8'hDA;
  localparam logic [7:0] CODE_DQT    = 8'hDB;
  localparam logic [7:0] CODE_DRI    = 8'hDD;
  localparam logic [7:0] CODE_APP0   = 8'hE0;
  localparam logic [7:0] CODE_APP1   = 8'hE1;
  localparam logic [7:0] CODE_APP14  = 8'hEE;

  localparam logic [15:0] MIN_LENGTH = 16'd2;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  marker_code;
    class_t      marker_class;
    logic [15:0] segment_length;
    logic [31:0] byte_offset;
  } res_t;

  function automatic class_t classify(input logic [7:0] code);
    class_t cls;
    cls = CL_OTHER;
    unique case (code) inside
      CODE_SOI:               cls = CL_SOI;
      CODE_SOF0:              cls = CL_SOF0;
      CODE_SOF2:              cls = CL_SOF2;
      CODE_DHT:               cls = CL_DHT;
      CODE_APP0:              cls = CL_APP0;
      [CODE_APP1:CODE_APP14]: cls = CL_APPN;
      [CODE_RST0:CODE_RST7]:  cls = CL_RST;
      CODE_SOS:               cls = CL_SOS;
      CODE_DQT:               cls = CL_DQT;
      CODE_DRI:               cls = CL_DRI;
      default:                cls = CL_OTHER;
    endcase
    return cls;
  endfunction

  function automatic logic is_scan_start(input class_t cls);
    return (cls == CL_RST) || (cls == CL_SOS);
  endfunction

endpackage

// File: hw/rtl/jmsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsp_step
// Parser state registers and the combinational next-state update for one stream byte;
// drives the result of the byte being accepted.
// ----------------------------------------------------------------------------
module jmsp_step #(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_eof,
  output jmsp_pkg::res_t res
);
  import jmsp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             marker_r, marker_nxt;
  logic [7:0]             len_hi_r, len_hi_nxt;
  logic [15:0]            left_r, left_nxt;
  logic [15:0]            seg_r, seg_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic                   prefix_r, prefix_nxt;
  event_t                 ev;
  logic [15:0]            len_full;
  logic [OFFSET_BITS+31:0] offset_ext;
  logic                   marker_scan;

  assign len_full    = {len_hi_r, in_byte};
  assign marker_scan = is_scan_start(classify(marker_r));

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    marker_nxt = marker_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    seg_nxt    = seg_r;
    offset_nxt = offset_r;
    prefix_nxt = prefix_r;
    if (phase_r != PH_STOPPED && phase_r != PH_FINISHED) begin
      if (in_eof) begin
        phase_nxt = PH_STOPPED;
      end else begin
        offset_nxt = offset_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        unique case (phase_r)
          PH_PREFIX: begin
            phase_nxt = (in_byte == BYTE_PREFIX) ? PH_CODE : PH_STOPPED;
          end
          PH_CODE: begin
            marker_nxt = in_byte;
            seg_nxt    = '0;
            if (classify(in_byte) == CL_OTHER) begin
              phase_nxt = PH_STOPPED;
            end else if (classify(in_byte) == CL_SOI) begin
              phase_nxt = PH_PREFIX;
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_hi_nxt = in_byte;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (len_full < MIN_LENGTH) begin
              phase_nxt = PH_STOPPED;
            end else begin
              seg_nxt  = len_full - MIN_LENGTH;
              left_nxt = len_full - MIN_LENGTH;
              if (len_full != MIN_LENGTH) begin
                phase_nxt = PH_PAYLOAD;
              end else if (marker_scan) begin
                prefix_nxt = 1'b0;
                phase_nxt  = PH_SCAN;
              end else begin
                phase_nxt = PH_PREFIX;
              end
            end
          end
          PH_PAYLOAD: begin
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1) begin
              if (marker_scan) begin
                prefix_nxt = 1'b0;
                phase_nxt  = PH_SCAN;
              end else begin
                phase_nxt = PH_PREFIX;
              end
            end
          end
          PH_SCAN: begin
            if (prefix_r) begin
              prefix_nxt = 1'b0;
              if (in_byte == CODE_EOI) begin
                phase_nxt = PH_FINISHED;
              end
            end else if (in_byte == BYTE_PREFIX) begin
              prefix_nxt = 1'b1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    ev = EV_NONE;
    if (phase_r != PH_STOPPED && phase_r != PH_FINISHED) begin
      if (in_eof) begin
        ev = EV_TRUNCATED;
      end else begin
        unique case (phase_r)
          PH_PREFIX: begin
            if (in_byte != BYTE_PREFIX) ev = EV_BAD_MARKER;
          end
          PH_CODE: begin
            ev = (classify(in_byte) == CL_OTHER) ? EV_BAD_MARKER : EV_MARKER;
          end
          PH_LEN_LO: begin
            if (len_full < MIN_LENGTH) begin
              ev = EV_BAD_LENGTH;
            end else if (len_full == MIN_LENGTH && marker_scan) begin
              ev = EV_SOS_DONE;
            end
          end
          PH_PAYLOAD: begin
            ev = (left_r == 16'd1 && marker_scan) ? EV_SOS_DONE : EV_PAYLOAD;
          end
          PH_SCAN: begin
            if (prefix_r && in_byte == CODE_EOI) ev = EV_EOI;
          end
          default: begin
            ev = EV_NONE;
          end
        endcase
      end
    end
  end

  assign offset_ext = {32'd0, offset_nxt};

  always_comb begin
    res.event_res      = ev;
    res.marker_code    = marker_nxt;
    res.marker_class   = classify(marker_nxt);
    res.segment_length = seg_nxt;
    res.byte_offset    = offset_ext[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      marker_r <= '0;
      len_hi_r <= '0;
      left_r   <= '0;
      seg_r    <= '0;
      offset_r <= '0;
      prefix_r <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      marker_r <= marker_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      seg_r    <= seg_nxt;
      offset_r <= offset_nxt;
      prefix_r <= prefix_nxt;
    end
  end

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOPPED |=> phase_r == PH_STOPPED)
    else $error("stopped parser left its stop state");

  a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINISHED |=> phase_r == PH_FINISHED && $stable(offset_r))
    else $error("finished parser changed state");

  a_eof_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_eof |=> offset_r == $past(offset_r))
    else $error("end of file advanced the byte offset");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 16'd0)
    else $error("payload phase with nothing left to skip");

endmodule

// File: hw/rtl/jmsp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsp_out_buf
// Result register with a skid stage; takes a request every cycle while the
// skid stage is empty.
// ----------------------------------------------------------------------------
module jmsp_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jmsp_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output jmsp_pkg::res_t out_data
);
  import jmsp_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic take;

  assign take      = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds a result ahead of the output register");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && out_stall && push && !skid_valid_r |=> skid_valid_r)
    else $error("request lost while output stalled");

endmodule

// File: hw/rtl/jpeg_marker_segment_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_segment_parser_top
// JPEG marker segment parser: walks SOI, segment headers and payloads, then
// scans entropy-coded data for EOI; one result per stream byte.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in_     | input     | in_valid, in_stall, in_byte_value, in_end_of_file
//   out_    | output    | out_valid, out_stall, out_event_res, out_marker_code,
//           |           | out_marker_class, out_segment_length, out_byte_offset
//
// One byte per cycle while in_stall is low; each result is registered in the output register or its skid stage.
// The parser state updates in the cycle of acceptance, from one register stage.
// Synchronous reset clears the parser state and the valid flags of both output stages.
// in_stall rises only when the output register and its skid stage are full,
// so one result can wait on out_stall without blocking the next request.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_parser_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_marker_code,
  output logic [3:0]  out_marker_class,
  output logic [15:0] out_segment_length,
  output logic [31:0] out_byte_offset
);
  import jmsp_pkg::*;

  logic in_fire;
  logic buf_full;
  res_t step_res;
  res_t out_res;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  jmsp_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_byte(in_byte_value),
    .in_eof (in_end_of_file),
    .res    (step_res)
  );

  jmsp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_data(step_res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_event_res      = out_res.event_res;
  assign out_marker_code    = out_res.marker_code;
  assign out_marker_class   = out_res.marker_class;
  assign out_segment_length = out_res.segment_length;
  assign out_byte_offset    = out_res.byte_offset;

endmodule
